/* hw/rtl/srvm_pkg.sv */
// Shared types and codes of the stack frame register VM core.
`default_nettype none
package srvm_pkg;

  typedef enum logic [4:0] {
    OP_NONE = 5'd0,
    OP_LIT  = 5'd1,
    OP_RET  = 5'd2,
    OP_LOD  = 5'd3,
    OP_STO  = 5'd4,
    OP_CAL  = 5'd5,
    OP_INC  = 5'd6,
    OP_JMP  = 5'd7,
    OP_JPC  = 5'd8,
    OP_SIO  = 5'd9,
    OP_NEG  = 5'd10,
    OP_ADD  = 5'd11,
    OP_SUB  = 5'd12,
    OP_MUL  = 5'd13,
    OP_DIV  = 5'd14,
    OP_ODD  = 5'd15,
    OP_MOD  = 5'd16,
    OP_EQL  = 5'd17,
    OP_NEQ  = 5'd18,
    OP_LSS  = 5'd19,
    OP_LEQ  = 5'd20,
    OP_GTR  = 5'd21,
    OP_GEQ  = 5'd22
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BOUNDS   = 3'd1,
    ERR_OVERFLOW = 3'd2,
    ERR_OPCODE   = 3'd3,
    ERR_DIVZERO  = 3'd4
  } err_e;

  localparam logic [15:0] SIO_WRITE = 16'd1;
  localparam logic [15:0] SIO_READ  = 16'd2;
  localparam logic [15:0] SIO_HALT  = 16'd3;

  typedef enum logic [1:0] {RS_L, RS_M, RS_R} rsel_e;
  typedef enum logic [2:0] {WS_LIT, WS_ALU, WS_RV, WS_MEM, WS_DIV} wsel_e;
  typedef enum logic [1:0] {MS_WALK, MS_ADDR, MS_RET2, MS_RET3} msel_e;
  typedef enum logic {MW_REG, MW_CAL} mwsel_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_RDR, S_CAPR, S_EXEC, S_WALK, S_WALKW,
    S_MEM, S_LODW, S_CALW, S_RET2, S_RET3, S_RETA, S_RETC, S_DIV
  } state_e;

  typedef struct packed {
    logic   clr;
    logic   load;
    rsel_e  rsel;
    logic   cap_a;
    logic   cap_b;
    logic   cap_r;
    logic   rf_we;
    wsel_e  wsel;
    logic   mem_rd;
    msel_e  msel;
    logic   mem_we;
    mwsel_e mwsel;
    logic   walk_start;
    logic   walk_step;
    logic   cap_nb;
    logic   cap_np;
    logic   ret_apply;
    logic   cal_step;
    logic   cal_apply;
    logic   st_add;
    logic   pc_load_m;
    logic   sio_out;
    logic   set_halt;
    logic   set_err;
    err_e   err_code;
    logic   div_start;
    logic   div_step;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic clr_done;
    logic halted;
    logic fb_one;
    logic ret_bad;
    logic cal_ovf;
    logic inc_ovf;
    logic lvl_done;
    logic idx_bad;
    logic addr_ovf;
    logic addr_in;
    logic r_zero;
    logic b_zero;
    logic sio_wr;
    logic sio_rd;
    logic sio_halt;
    logic cal_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/srvm_if.sv */
// Valid/ready channel interfaces for instructions and results.
`default_nettype none
interface srvm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  opcode;
  logic [3:0]  reg_dest;
  logic [3:0]  level_or_reg;
  logic [15:0] m_operand;
  logic signed [31:0] read_value;
  modport source (output valid, opcode, reg_dest, level_or_reg, m_operand, read_value,
                  input ready);
  modport sink (input valid, opcode, reg_dest, level_or_reg, m_operand, read_value,
                output ready);
endinterface

interface srvm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        out_valid;
  logic signed [31:0] out_value;
  logic        halted;
  logic [2:0]  error_code;
  modport source (output valid, next_pc, out_valid, out_value, halted, error_code,
                  input ready);
  modport sink (input valid, next_pc, out_valid, out_value, halted, error_code,
                output ready);
endinterface
`default_nettype wire

/* hw/rtl/stack_frame_register_vm_core_unit.sv */
// Top level of the PM/0 stack frame register VM core.
// The item_i channel takes one decoded instruction per transaction; the
// result_o channel returns one transaction per instruction with the next pc,
// any SIO write value, the halt flag and the latched error code.
// After reset the block clears its data stack and register file, one entry
// of each per cycle, and keeps item_i.ready low during that pass.
// One instruction is worked at a time by a sequencer over register file and
// stack memories with one read port each: it reads the three operand
// registers in turn, then executes. lod and sto first walk the static link
// chain one level at a time, cal walks it and then writes the four frame
// words, ret reads the two saved words, and div and mod run the bit-serial
// divider. Once halted, an item goes straight to the result register.
// The result sits in an output register; the next instruction is accepted
// while it waits, and its own result waits until result_o takes the first.
`default_nettype none
module stack_frame_register_vm_core_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int REG_COUNT   = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srvm_in_if.sink   item_i,
  srvm_out_if.source result_o
);

  srvm_pkg::cmd_t cmd;
  srvm_pkg::sts_t sts;

  srvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srvm_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .REG_COUNT   (REG_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (item_i.opcode),
    .reg_dest_i     (item_i.reg_dest),
    .level_or_reg_i (item_i.level_or_reg),
    .m_operand_i    (item_i.m_operand),
    .read_value_i   (item_i.read_value),
    .res_valid_o    (result_o.valid),
    .res_ready_i    (result_o.ready),
    .next_pc_o      (result_o.next_pc),
    .out_valid_o    (result_o.out_valid),
    .out_value_o    (result_o.out_value),
    .halted_o       (result_o.halted),
    .error_code_o   (result_o.error_code)
  );

endmodule
`default_nettype wire

/* hw/rtl/srvm_ctrl.sv */
// Instruction sequencer of the VM core.
`default_nettype none
module srvm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire srvm_pkg::sts_t  sts_i,
  output srvm_pkg::cmd_t       cmd_o
);

  srvm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srvm_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      srvm_pkg::S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = srvm_pkg::S_IDLE;
      end
      srvm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // A halted machine only reports its held state.
          state_d = sts_i.halted ? srvm_pkg::S_RETC : srvm_pkg::S_RDA;
        end
      end
      srvm_pkg::S_RDA: begin
        cmd_o.rsel = srvm_pkg::RS_L;
        state_d    = srvm_pkg::S_RDB;
      end
      srvm_pkg::S_RDB: begin
        cmd_o.rsel  = srvm_pkg::RS_M;
        cmd_o.cap_a = 1'b1;
        state_d     = srvm_pkg::S_RDR;
      end
      srvm_pkg::S_RDR: begin
        cmd_o.rsel  = srvm_pkg::RS_R;
        cmd_o.cap_b = 1'b1;
        state_d     = srvm_pkg::S_CAPR;
      end
      srvm_pkg::S_CAPR: begin
        cmd_o.cap_r = 1'b1;
        state_d     = srvm_pkg::S_EXEC;
      end
      srvm_pkg::S_EXEC: begin
        state_d = srvm_pkg::S_RETC;
        case (sts_i.op)
          srvm_pkg::OP_LIT: begin
            cmd_o.rf_we = 1'b1;
            cmd_o.wsel  = srvm_pkg::WS_LIT;
          end
          srvm_pkg::OP_RET: begin
            if (!sts_i.fb_one) begin
              cmd_o.mem_rd = 1'b1;
              cmd_o.msel   = srvm_pkg::MS_RET2;
              state_d      = srvm_pkg::S_RET2;
            end
          end
          srvm_pkg::OP_LOD, srvm_pkg::OP_STO: begin
            cmd_o.walk_start = 1'b1;
            state_d          = srvm_pkg::S_WALK;
          end
          srvm_pkg::OP_CAL: begin
            if (sts_i.cal_ovf) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = srvm_pkg::ERR_OVERFLOW;
            end else begin
              cmd_o.walk_start = 1'b1;
              state_d          = srvm_pkg::S_WALK;
            end
          end
          srvm_pkg::OP_INC: begin
            if (sts_i.inc_ovf) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = srvm_pkg::ERR_OVERFLOW;
            end else begin
              cmd_o.st_add = 1'b1;
            end
          end
          srvm_pkg::OP_JMP: cmd_o.pc_load_m = 1'b1;
          srvm_pkg::OP_JPC: cmd_o.pc_load_m = sts_i.r_zero;
          srvm_pkg::OP_SIO: begin
            cmd_o.sio_out  = sts_i.sio_wr;
            cmd_o.rf_we    = sts_i.sio_rd;
            cmd_o.wsel     = srvm_pkg::WS_RV;
            cmd_o.set_halt = sts_i.sio_halt;
          end
          srvm_pkg::OP_NEG, srvm_pkg::OP_ADD, srvm_pkg::OP_SUB, srvm_pkg::OP_MUL,
          srvm_pkg::OP_ODD, srvm_pkg::OP_EQL, srvm_pkg::OP_NEQ, srvm_pkg::OP_LSS,
          srvm_pkg::OP_LEQ, srvm_pkg::OP_GTR, srvm_pkg::OP_GEQ: begin
            cmd_o.rf_we = 1'b1;
            cmd_o.wsel  = srvm_pkg::WS_ALU;
          end
          srvm_pkg::OP_DIV, srvm_pkg::OP_MOD: begin
            if (sts_i.b_zero) begin
              cmd_o.set_err  = 1'b1;
              cmd_o.err_code = srvm_pkg::ERR_DIVZERO;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = srvm_pkg::S_DIV;
            end
          end
          default: begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = srvm_pkg::ERR_OPCODE;
          end
        endcase
      end
      srvm_pkg::S_WALK: begin
        if (sts_i.lvl_done) begin
          state_d = (sts_i.op == srvm_pkg::OP_CAL) ? srvm_pkg::S_CALW : srvm_pkg::S_MEM;
        end else if (sts_i.idx_bad) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = srvm_pkg::ERR_BOUNDS;
          state_d        = srvm_pkg::S_RETC;
        end else begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.msel   = srvm_pkg::MS_WALK;
          state_d      = srvm_pkg::S_WALKW;
        end
      end
      srvm_pkg::S_WALKW: begin
        cmd_o.walk_step = 1'b1;
        state_d         = srvm_pkg::S_WALK;
      end
      srvm_pkg::S_MEM: begin
        state_d = srvm_pkg::S_RETC;
        if (sts_i.addr_ovf) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = (sts_i.op == srvm_pkg::OP_LOD) ? srvm_pkg::ERR_BOUNDS
                                                          : srvm_pkg::ERR_OVERFLOW;
        end else if (!sts_i.addr_in) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = srvm_pkg::ERR_BOUNDS;
        end else if (sts_i.op == srvm_pkg::OP_LOD) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.msel   = srvm_pkg::MS_ADDR;
          state_d      = srvm_pkg::S_LODW;
        end else begin
          cmd_o.mem_we = 1'b1;
          cmd_o.mwsel  = srvm_pkg::MW_REG;
        end
      end
      srvm_pkg::S_LODW: begin
        cmd_o.rf_we = 1'b1;
        cmd_o.wsel  = srvm_pkg::WS_MEM;
        state_d     = srvm_pkg::S_RETC;
      end
      srvm_pkg::S_CALW: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.mwsel    = srvm_pkg::MW_CAL;
        cmd_o.cal_step = 1'b1;
        if (sts_i.cal_last) begin
          cmd_o.cal_apply = 1'b1;
          state_d         = srvm_pkg::S_RETC;
        end
      end
      srvm_pkg::S_RET2: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.msel   = srvm_pkg::MS_RET3;
        cmd_o.cap_nb = 1'b1;
        state_d      = srvm_pkg::S_RET3;
      end
      srvm_pkg::S_RET3: begin
        cmd_o.cap_np = 1'b1;
        state_d      = srvm_pkg::S_RETA;
      end
      srvm_pkg::S_RETA: begin
        // Both saved words are held now, so the frame can be checked and restored.
        if (sts_i.ret_bad) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = srvm_pkg::ERR_BOUNDS;
        end else begin
          cmd_o.ret_apply = 1'b1;
        end
        state_d = srvm_pkg::S_RETC;
      end
      srvm_pkg::S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.rf_we = 1'b1;
          cmd_o.wsel  = srvm_pkg::WS_DIV;
          state_d     = srvm_pkg::S_RETC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      default: begin
        // Finish: hand the result to the output register.
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = srvm_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/srvm_dpath.sv */
// Machine state, memories, ALU, divider and result register of the VM core.
`default_nettype none
module srvm_dpath #(
  parameter int STACK_DEPTH = 64,
  parameter int REG_COUNT   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire srvm_pkg::cmd_t     cmd_i,
  output srvm_pkg::sts_t          sts_o,
  input  wire logic [4:0]         opcode_i,
  input  wire logic [3:0]         reg_dest_i,
  input  wire logic [3:0]         level_or_reg_i,
  input  wire logic [15:0]        m_operand_i,
  input  wire logic signed [31:0] read_value_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [15:0]             next_pc_o,
  output logic                    out_valid_o,
  output logic signed [31:0]      out_value_o,
  output logic                    halted_o,
  output logic [2:0]              error_code_o
);

  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int RIW   = $clog2(REG_COUNT);
  localparam int CLR_N = (STACK_DEPTH > REG_COUNT) ? STACK_DEPTH : REG_COUNT;
  localparam int CW    = $clog2(CLR_N);

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] rf_mem  [REG_COUNT];

  logic [4:0]  op_q;
  logic [3:0]  rd_idx_q, lv_q;
  logic [15:0] m_q;
  logic [31:0] rv_q;
  logic [31:0] a_q, b_q, r_q;
  logic [31:0] rf_rdata_q, stk_rdata_q;
  logic        rf_hit_q;
  logic [15:0] pc_q;
  logic [SAW-1:0] fb_q, st_q;
  logic        halt_q;
  logic [2:0]  err_q;
  logic [CW-1:0] clr_q;
  logic signed [31:0] base_q;
  logic [3:0]  lvl_q;
  logic [1:0]  cal_k_q;
  logic [31:0] nb_q, np_q;
  logic        sio_q;
  logic [31:0] sio_val_q;
  logic [31:0] dvd_q, dvs_q;
  logic [32:0] rem_q;
  logic [5:0]  div_cnt_q;
  logic        qneg_q, rneg_q;
  logic        ovld_q;

  // Register file port.
  logic [15:0]    rf_ridx;
  logic           rf_rhit;
  logic           rf_we;
  logic [RIW-1:0] rf_waddr;
  logic [31:0]    rf_wdata, alu_res, div_res;

  always_comb begin
    case (cmd_i.rsel)
      srvm_pkg::RS_L: rf_ridx = {12'd0, lv_q};
      srvm_pkg::RS_M: rf_ridx = m_q;
      default:        rf_ridx = {12'd0, rd_idx_q};
    endcase
  end
  assign rf_rhit = 32'(rf_ridx) < 32'(REG_COUNT);

  always_comb begin
    case (srvm_pkg::op_e'(op_q))
      srvm_pkg::OP_NEG: alu_res = 32'd0 - r_q;
      srvm_pkg::OP_ADD: alu_res = a_q + b_q;
      srvm_pkg::OP_SUB: alu_res = a_q - b_q;
      srvm_pkg::OP_MUL: alu_res = a_q * b_q;
      srvm_pkg::OP_ODD: alu_res = {31'd0, b_q[0]};
      srvm_pkg::OP_EQL: alu_res = {31'd0, a_q == b_q};
      srvm_pkg::OP_NEQ: alu_res = {31'd0, a_q != b_q};
      srvm_pkg::OP_LSS: alu_res = {31'd0, $signed(a_q) < $signed(b_q)};
      srvm_pkg::OP_LEQ: alu_res = {31'd0, $signed(a_q) <= $signed(b_q)};
      srvm_pkg::OP_GTR: alu_res = {31'd0, $signed(a_q) > $signed(b_q)};
      srvm_pkg::OP_GEQ: alu_res = {31'd0, $signed(a_q) >= $signed(b_q)};
      default:          alu_res = 32'd0;
    endcase
  end

  assign div_res = (srvm_pkg::op_e'(op_q) == srvm_pkg::OP_DIV)
                 ? (qneg_q ? 32'd0 - dvd_q : dvd_q)
                 : (rneg_q ? 32'd0 - rem_q[31:0] : rem_q[31:0]);

  always_comb begin
    case (cmd_i.wsel)
      srvm_pkg::WS_LIT: rf_wdata = {16'd0, m_q};
      srvm_pkg::WS_ALU: rf_wdata = alu_res;
      srvm_pkg::WS_RV:  rf_wdata = rv_q;
      srvm_pkg::WS_MEM: rf_wdata = stk_rdata_q;
      default:          rf_wdata = div_res;
    endcase
    if (cmd_i.clr) begin
      rf_we    = 32'(clr_q) < 32'(REG_COUNT);
      rf_waddr = clr_q[RIW-1:0];
      rf_wdata = 32'd0;
    end else begin
      rf_we    = cmd_i.rf_we && (32'(rd_idx_q) < 32'(REG_COUNT));
      rf_waddr = RIW'(rd_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_ridx[RIW-1:0]];
    rf_hit_q   <= rf_rhit;
  end

  // Stack address arithmetic.
  logic signed [32:0] walk_idx;
  logic signed [33:0] addr;
  logic [SAW-1:0]     stk_raddr, stk_waddr;
  logic               stk_we;
  logic [31:0]        stk_wdata, cal_data;

  assign walk_idx = {base_q[31], base_q} + 33'sd1;
  assign addr     = {{2{base_q[31]}}, base_q} + $signed({18'd0, m_q});

  always_comb begin
    case (cmd_i.msel)
      srvm_pkg::MS_WALK: stk_raddr = walk_idx[SAW-1:0];
      srvm_pkg::MS_ADDR: stk_raddr = addr[SAW-1:0];
      srvm_pkg::MS_RET2: stk_raddr = SAW'(32'(fb_q) + 32'd2);
      default:           stk_raddr = SAW'(32'(fb_q) + 32'd3);
    endcase
    case (cal_k_q)
      2'd0:    cal_data = 32'd0;
      2'd1:    cal_data = base_q;
      2'd2:    cal_data = 32'(fb_q);
      default: cal_data = {16'd0, pc_q};
    endcase
    if (cmd_i.clr) begin
      stk_we    = 32'(clr_q) < 32'(STACK_DEPTH);
      stk_waddr = clr_q[SAW-1:0];
      stk_wdata = 32'd0;
    end else if (cmd_i.mwsel == srvm_pkg::MW_CAL) begin
      stk_we    = cmd_i.mem_we;
      stk_waddr = SAW'(32'(st_q) + 32'd1 + 32'(cal_k_q));
      stk_wdata = cal_data;
    end else begin
      stk_we    = cmd_i.mem_we;
      stk_waddr = addr[SAW-1:0];
      stk_wdata = r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (cmd_i.mem_rd) stk_rdata_q <= stk_mem[stk_raddr];
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= opcode_i;
      rd_idx_q <= reg_dest_i;
      lv_q     <= level_or_reg_i;
      m_q      <= m_operand_i;
      rv_q     <= read_value_i;
    end
    if (cmd_i.cap_a) a_q <= rf_hit_q ? rf_rdata_q : 32'd0;
    if (cmd_i.cap_b) b_q <= rf_hit_q ? rf_rdata_q : 32'd0;
    if (cmd_i.cap_r) r_q <= rf_hit_q ? rf_rdata_q : 32'd0;
    if (cmd_i.walk_start) begin
      base_q <= $signed(32'(fb_q));
    end else if (cmd_i.walk_step) begin
      base_q <= $signed(stk_rdata_q);
    end
    if (cmd_i.cap_nb) nb_q <= stk_rdata_q;
    if (cmd_i.cap_np) np_q <= stk_rdata_q;
    if (cmd_i.div_start) begin
      dvd_q  <= a_q[31] ? 32'd0 - a_q : a_q;
      dvs_q  <= b_q[31] ? 32'd0 - b_q : b_q;
      rem_q  <= 33'd0;
      qneg_q <= a_q[31] ^ b_q[31];
      rneg_q <= a_q[31];
    end else if (cmd_i.div_step) begin
      // One restoring step: shift in the next dividend bit and try to subtract.
      if ({rem_q[31:0], dvd_q[31]} >= {1'b0, dvs_q}) begin
        rem_q <= {rem_q[31:0], dvd_q[31]} - {1'b0, dvs_q};
        dvd_q <= {dvd_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[31:0], dvd_q[31]};
        dvd_q <= {dvd_q[30:0], 1'b0};
      end
    end
    if (cmd_i.sio_out) sio_val_q <= r_q;
    if (cmd_i.out_load) begin
      next_pc_o    <= pc_q;
      out_valid_o  <= sio_q;
      out_value_o  <= sio_q ? $signed(sio_val_q) : 32'sd0;
      halted_o     <= halt_q;
      error_code_o <= err_q;
    end
  end

  // Machine state and control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= 16'd0;
      fb_q      <= SAW'(1);
      st_q      <= '0;
      halt_q    <= 1'b0;
      err_q     <= srvm_pkg::ERR_NONE;
      clr_q     <= '0;
      lvl_q     <= 4'd0;
      cal_k_q   <= 2'd0;
      div_cnt_q <= 6'd0;
      sio_q     <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + CW'(1);
      if (cmd_i.load) begin
        if (!halt_q) pc_q <= pc_q + 16'd1;
        cal_k_q <= 2'd0;
        sio_q   <= 1'b0;
      end
      if (cmd_i.pc_load_m) pc_q <= m_q;
      if (cmd_i.st_add) st_q <= SAW'(32'(st_q) + 32'(m_q));
      if (cmd_i.walk_start) begin
        lvl_q <= 4'd0;
      end else if (cmd_i.walk_step) begin
        lvl_q <= lvl_q + 4'd1;
      end
      if (cmd_i.cal_step) cal_k_q <= cal_k_q + 2'd1;
      if (cmd_i.cal_apply) begin
        fb_q <= st_q + SAW'(1);
        pc_q <= m_q;
      end
      if (cmd_i.ret_apply) begin
        st_q <= fb_q - SAW'(1);
        fb_q <= nb_q[SAW-1:0];
        pc_q <= np_q[15:0];
      end
      if (cmd_i.sio_out) sio_q <= 1'b1;
      if (cmd_i.set_halt) halt_q <= 1'b1;
      if (cmd_i.set_err) begin
        halt_q <= 1'b1;
        err_q  <= cmd_i.err_code;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= 6'd0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 6'd1;
      end
      if (cmd_i.out_load) begin
        ovld_q <= 1'b1;
      end else if (res_ready_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = ovld_q;

  always_comb begin
    sts_o.op       = srvm_pkg::op_e'(op_q);
    sts_o.clr_done = 32'(clr_q) == 32'(CLR_N - 1);
    sts_o.halted   = halt_q;
    sts_o.fb_one   = 32'(fb_q) == 32'd1;
    sts_o.ret_bad  = (fb_q == '0) || (32'(fb_q) + 32'd3 >= 32'(STACK_DEPTH))
                  || ($signed(nb_q) < 32'sd1)
                  || ($signed(nb_q) > $signed(32'(STACK_DEPTH - 4)));
    sts_o.cal_ovf  = 32'(st_q) + 32'd4 >= 32'(STACK_DEPTH);
    sts_o.inc_ovf  = 32'(st_q) + 32'(m_q) >= 32'(STACK_DEPTH);
    sts_o.lvl_done = lvl_q == lv_q;
    sts_o.idx_bad  = (walk_idx < 33'sd0) || (walk_idx >= $signed(33'(STACK_DEPTH)));
    sts_o.addr_ovf = addr >= $signed(34'(STACK_DEPTH));
    sts_o.addr_in  = (addr > 34'sd0) && (addr <= $signed(34'(st_q)));
    sts_o.r_zero   = r_q == 32'd0;
    sts_o.b_zero   = b_q == 32'd0;
    sts_o.sio_wr   = m_q == srvm_pkg::SIO_WRITE;
    sts_o.sio_rd   = m_q == srvm_pkg::SIO_READ;
    sts_o.sio_halt = m_q == srvm_pkg::SIO_HALT;
    sts_o.cal_last = cal_k_q == 2'd3;
    sts_o.div_done = div_cnt_q == 6'd32;
    sts_o.out_free = !ovld_q || res_ready_i;
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt flag was cleared");
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != srvm_pkg::ERR_NONE) |-> halt_q) else $error("error without halt");
  a_frame_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fb_q) + 32'd3 < 32'(STACK_DEPTH)) && (fb_q != '0))
    else $error("frame base out of stack");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!ovld_q || res_ready_i)) else $error("result overwritten");

endmodule
`default_nettype wire

/* bench/vm_checker.sv */
// Checker for the PM/0 VM core: predicts every result and compares it.
`timescale 1ns / 1ps
module vm_checker (
  input  logic clk_i,
  input  logic rst_ni,
  srvm_in_if   in_ch,
  srvm_out_if  out_ch,
  output int   fail_count_o,
  output int   pending_o
);
  import srvm_pkg::*;

  localparam int DEPTH = 64;
  localparam int NREGS = 16;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        out_valid;
    logic [31:0] out_value;
    logic        halted;
    logic [2:0]  error_code;
  } vm_result_t;

  vm_result_t  expected_q[$];
  logic [15:0] pc;
  logic [6:0]  fb;
  logic [6:0]  st;
  logic [31:0] regs [NREGS];
  logic [31:0] stk [DEPTH];
  logic        halt_q;
  err_e        err_latch;

  function automatic logic [31:0] reg_rd(int unsigned i);
    return (i < NREGS) ? regs[i] : 32'd0;
  endfunction

  function automatic void reg_wr(int unsigned i, logic [31:0] v);
    if (i < NREGS) regs[i] = v;
  endfunction

  // Follows static links; fails when a link cell lies outside the stack.
  function automatic bit walk_links(int unsigned lv, output longint b_o);
    longint b;
    longint idx;
    b = fb;
    for (int k = 0; k < lv; k++) begin
      idx = b + 1;
      if (idx < 0 || idx >= DEPTH) return 0;
      b = longint'($signed(stk[idx]));
    end
    b_o = b;
    return 1;
  endfunction

  function automatic vm_result_t run_instr(logic [4:0] op, logic [3:0] r, logic [3:0] l,
                                           logic [15:0] m, logic [31:0] rv);
    vm_result_t res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] nb;
    logic [31:0] np;
    longint      base;
    longint      addr;
    longint      snb;
    longint      sa;
    longint      sb;
    longint      q;
    err_e        err;
    bit          stop;
    a = reg_rd(l);
    b = reg_rd(m);
    err = ERR_NONE;
    stop = 0;
    res = '0;
    if (!halt_q) begin
      pc = pc + 16'd1;
      case (op)
        OP_LIT: reg_wr(r, {16'd0, m});
        OP_RET: begin
          if (fb != 7'd1) begin
            nb = stk[(int'(fb) + 2) % DEPTH];
            np = stk[(int'(fb) + 3) % DEPTH];
            snb = longint'($signed(nb));
            if (fb < 1 || int'(fb) + 3 >= DEPTH || snb < 1 || snb > DEPTH - 4) begin
              err = ERR_BOUNDS;
            end else begin
              st = fb - 7'd1;
              fb = snb[6:0];
              pc = np[15:0];
            end
          end
        end
        OP_LOD, OP_STO: begin
          if (!walk_links(l, base)) begin
            err = ERR_BOUNDS;
          end else begin
            addr = base + longint'(m);
            if (addr >= DEPTH) err = (op == OP_LOD) ? ERR_BOUNDS : ERR_OVERFLOW;
            else if (addr > 0 && addr <= st) begin
              if (op == OP_LOD) reg_wr(r, stk[addr]);
              else stk[addr] = reg_rd(r);
            end else err = ERR_BOUNDS;
          end
        end
        OP_CAL: begin
          if (int'(st) + 4 >= DEPTH) err = ERR_OVERFLOW;
          else if (!walk_links(l, base)) err = ERR_BOUNDS;
          else begin
            stk[st + 1] = 32'd0;
            stk[st + 2] = base[31:0];
            stk[st + 3] = {25'd0, fb};
            stk[st + 4] = {16'd0, pc};
            fb = st + 7'd1;
            pc = m;
          end
        end
        OP_INC: begin
          if (int'(st) + int'(m) >= DEPTH) err = ERR_OVERFLOW;
          else st = st + m[6:0];
        end
        OP_JMP: pc = m;
        OP_JPC: if (reg_rd(r) == 32'd0) pc = m;
        OP_SIO: begin
          if (m == SIO_WRITE) begin
            res.out_valid = 1'b1;
            res.out_value = reg_rd(r);
          end else if (m == SIO_READ) reg_wr(r, rv);
          else if (m == SIO_HALT) stop = 1;
        end
        OP_NEG: reg_wr(r, 32'd0 - reg_rd(r));
        OP_ADD: reg_wr(r, a + b);
        OP_SUB: reg_wr(r, a - b);
        OP_MUL: reg_wr(r, a * b);
        OP_DIV, OP_MOD: begin
          if (b == 32'd0) err = ERR_DIVZERO;
          else begin
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            q = (op == OP_DIV) ? sa / sb : sa % sb;
            reg_wr(r, q[31:0]);
          end
        end
        OP_ODD: reg_wr(r, {31'd0, b[0]});
        OP_EQL: reg_wr(r, {31'd0, a == b});
        OP_NEQ: reg_wr(r, {31'd0, a != b});
        OP_LSS: reg_wr(r, {31'd0, $signed(a) < $signed(b)});
        OP_LEQ: reg_wr(r, {31'd0, $signed(a) <= $signed(b)});
        OP_GTR: reg_wr(r, {31'd0, $signed(a) > $signed(b)});
        OP_GEQ: reg_wr(r, {31'd0, $signed(a) >= $signed(b)});
        default: err = ERR_OPCODE;
      endcase
      if (err != ERR_NONE) begin
        stop = 1;
        err_latch = err;
      end
      if (stop) halt_q = 1'b1;
    end
    res.next_pc = pc;
    res.halted = halt_q;
    res.error_code = err_latch;
    return res;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t ns: %s is %0h, predicted %0h", $time, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vm_result_t want;
    if (!rst_ni) begin
      pc = '0;
      fb = 7'd1;
      st = '0;
      for (int i = 0; i < NREGS; i++) regs[i] = '0;
      for (int i = 0; i < DEPTH; i++) stk[i] = '0;
      halt_q = 1'b0;
      err_latch = ERR_NONE;
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result transaction with nothing outstanding", $time);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.next_pc !== want.next_pc)
            report("next_pc", out_ch.next_pc, want.next_pc);
          if (out_ch.out_valid !== want.out_valid)
            report("out_valid", out_ch.out_valid, want.out_valid);
          if (out_ch.out_value !== want.out_value)
            report("out_value", out_ch.out_value, want.out_value);
          if (out_ch.halted !== want.halted)
            report("halted", out_ch.halted, want.halted);
          if (out_ch.error_code !== want.error_code)
            report("error_code", out_ch.error_code, want.error_code);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(run_instr(in_ch.opcode, in_ch.reg_dest, in_ch.level_or_reg,
                                       in_ch.m_operand, in_ch.read_value));
    end
    pending_o = expected_q.size();
  end
endmodule

/* bench/tb_top.sv */
// Top of the VM core testbench: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import srvm_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int N_ITEMS    = 1500;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   idle_on;
  bit   done;
  int   n_sent;

  // Shadow of the frame layout, kept only to build legal programs.
  int   sp;
  int   fr_bp[$];
  int   fr_sl[$];

  srvm_in_if  item_ch ();
  srvm_out_if res_ch ();

  stack_frame_register_vm_core_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_ch),
    .result_o(res_ch)
  );

  vm_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (item_ch),
    .out_ch      (res_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && !done) begin
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("stack_frame_register_vm_core_unit: mismatch");
          $finish;
        end
      end
    end
  end

  // Result side: a random stall before each transaction while idle_on is set.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  function automatic int link_hops(int k);
    int n;
    n = 0;
    while (k != 0) begin
      k = fr_sl[k];
      n++;
    end
    return n;
  endfunction

  function automatic int walked_frame(int lv);
    int k;
    k = fr_bp.size() - 1;
    repeat (lv) k = fr_sl[k];
    return k;
  endfunction

  task automatic send_instr(logic [4:0] op, logic [3:0] r, logic [3:0] l, logic [15:0] m,
                            logic [31:0] rv = $urandom());
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.reg_dest     <= r;
    item_ch.level_or_reg <= l;
    item_ch.m_operand    <= m;
    item_ch.read_value   <= rv;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    n_sent++;
    case (op)
      OP_INC: sp += m;
      OP_CAL: begin
        fr_sl.push_back(walked_frame(l));
        fr_bp.push_back(sp + 1);
      end
      OP_RET: begin
        if (fr_bp.size() > 1) begin
          sp = fr_bp[$] - 1;
          void'(fr_bp.pop_back());
          void'(fr_sl.pop_back());
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_mem_access(bit is_store);
    int   lv;
    int   base;
    int   lo;
    int   m;
    int   addr;
    bit   hdr;
    logic [4:0] op;
    lv = $urandom_range(0, link_hops(fr_bp.size() - 1));
    base = fr_bp[walked_frame(lv)];
    lo = is_store ? 4 : 0;
    if (base + lo > sp) begin
      send_instr(OP_LIT, $urandom(), $urandom(), $urandom());
    end else begin
      m = $urandom_range(lo, sp - base);
      addr = base + m;
      hdr = 0;
      // A store must never clobber the link cells of a live frame.
      for (int j = 1; j < fr_bp.size(); j++)
        if (addr >= fr_bp[j] && addr <= fr_bp[j] + 3) hdr = 1;
      op = (is_store && !hdr) ? OP_STO : OP_LOD;
      send_instr(op, $urandom(), lv, m);
    end
  endtask

  task automatic send_random_instr();
    int         c;
    int         m;
    logic [3:0] rb;
    logic [4:0] op;
    c = $urandom_range(0, 99);
    if (c < 12) send_instr(OP_LIT, $urandom(), $urandom(), $urandom());
    else if (c < 20) send_instr(OP_SIO, $urandom(), $urandom(), SIO_READ, $urandom());
    else if (c < 25) send_instr(OP_SIO, $urandom(), $urandom(), SIO_WRITE);
    else if (c < 27) send_instr(OP_SIO, $urandom(), $urandom(),
                                ($urandom_range(0, 1) != 0) ? 16'd0 : $urandom_range(4, 65535));
    else if (c < 45) begin
      do op = $urandom_range(OP_NEG, OP_GEQ); while (op == OP_DIV || op == OP_MOD);
      m = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
      send_instr(op, $urandom(), $urandom(), m);
    end else if (c < 52) begin
      rb = $urandom();
      send_instr(OP_LIT, rb, $urandom(), $urandom_range(1, 65535));
      if ($urandom_range(0, 1) != 0) send_instr(OP_NEG, rb, $urandom(), $urandom());
      send_instr(($urandom_range(0, 1) != 0) ? OP_DIV : OP_MOD, $urandom(), $urandom(), rb);
    end else if (c < 62) send_mem_access(0);
    else if (c < 70) send_mem_access(1);
    else if (c < 74) begin
      m = $urandom_range(0, 6);
      if (sp + m <= 50) send_instr(OP_INC, $urandom(), $urandom(), m);
      else send_instr(OP_INC, $urandom(), $urandom(), 16'd0);
    end else if (c < 80) begin
      if (sp <= 40 && fr_bp.size() < 7) begin
        send_instr(OP_CAL, $urandom(), $urandom_range(0, link_hops(fr_bp.size() - 1)),
                   $urandom());
        send_instr(OP_INC, $urandom(), $urandom(), $urandom_range(4, 7));
      end else send_instr(OP_RET, $urandom(), $urandom(), $urandom());
    end else if (c < 86) send_instr(OP_RET, $urandom(), $urandom(), $urandom());
    else if (c < 92) send_instr(OP_JMP, $urandom(), $urandom(), $urandom());
    else send_instr(OP_JPC, $urandom(), $urandom(), $urandom());
  endtask

  initial begin
    int kind;
    rst_n                <= 1'b0;
    item_ch.valid        <= 1'b0;
    item_ch.opcode       <= '0;
    item_ch.reg_dest     <= '0;
    item_ch.level_or_reg <= '0;
    item_ch.m_operand    <= '0;
    item_ch.read_value   <= '0;
    idle_cycles = 0;
    idle_on = 1;
    done = 0;
    n_sent = 0;
    sp = 0;
    fr_bp.push_back(1);
    fr_sl.push_back(0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme values, signed division corners, every operation.
    send_instr(OP_LIT, 4'd0, 4'd0, 16'hFFFF);
    send_instr(OP_LIT, 4'd1, 4'd15, 16'h0000);
    send_instr(OP_SIO, 4'd2, 4'd0, SIO_READ, 32'h8000_0000);
    send_instr(OP_SIO, 4'd3, 4'd0, SIO_READ, 32'hFFFF_FFFF);
    send_instr(OP_SIO, 4'd4, 4'd0, SIO_READ, 32'h7FFF_FFFF);
    send_instr(OP_DIV, 4'd5, 4'd2, 16'd3);
    send_instr(OP_MOD, 4'd6, 4'd2, 16'd3);
    send_instr(OP_MOD, 4'd7, 4'd3, 16'd0);
    send_instr(OP_ODD, 4'd8, 4'd0, 16'd3);
    send_instr(OP_NEG, 4'd2, 4'd0, 16'd0);
    send_instr(OP_LSS, 4'd10, 4'd2, 16'd4);
    send_instr(OP_GEQ, 4'd11, 4'd4, 16'd2);
    send_instr(OP_ADD, 4'd12, 4'd4, 16'd4);
    send_instr(OP_MUL, 4'd13, 4'd4, 16'hFFFF);
    send_instr(OP_SUB, 4'd14, 4'd2, 16'd4);
    send_instr(OP_EQL, 4'd15, 4'd3, 16'd3);
    send_instr(OP_NEQ, 4'd9, 4'd3, 16'd2);
    send_instr(OP_LEQ, 4'd9, 4'd2, 16'd2);
    send_instr(OP_GTR, 4'd9, 4'd4, 16'd2);
    send_instr(OP_SIO, 4'd2, 4'd0, SIO_WRITE);
    send_instr(OP_SIO, 4'd2, 4'd0, 16'd0);
    send_instr(OP_RET, 4'd0, 4'd0, 16'd0);
    send_instr(OP_JPC, 4'd1, 4'd0, 16'hABCD);
    send_instr(OP_JPC, 4'd0, 4'd0, 16'h1234);
    send_instr(OP_JMP, 4'd0, 4'd0, 16'hFFFF);
    send_instr(OP_INC, 4'd0, 4'd0, 16'd8);
    send_instr(OP_STO, 4'd4, 4'd0, 16'd5);
    send_instr(OP_LOD, 4'd12, 4'd0, 16'd5);
    send_instr(OP_CAL, 4'd0, 4'd0, 16'd20);
    send_instr(OP_INC, 4'd0, 4'd0, 16'd5);
    send_instr(OP_LOD, 4'd13, 4'd1, 16'd5);
    send_instr(OP_STO, 4'd2, 4'd0, 16'd4);
    send_instr(OP_RET, 4'd0, 4'd0, 16'd0);

    while (n_sent < N_ITEMS) begin
      if (n_sent % 100 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_random_instr();
    end

    // One terminating event: the machine halts once and ignores what follows.
    kind = $urandom_range(0, 6);
    case (kind)
      0: send_instr($urandom_range(0, 1) != 0 ? 5'd0 : $urandom_range(23, 31),
                    $urandom(), $urandom(), $urandom());
      1: send_instr(($urandom_range(0, 1) != 0) ? OP_DIV : OP_MOD, $urandom(), $urandom(),
                    $urandom_range(16, 65535));
      2: send_instr(OP_SIO, $urandom(), $urandom(), SIO_HALT);
      3: send_instr(OP_INC, $urandom(), $urandom(), 16'hFFFF);
      4: send_instr(OP_LOD, $urandom(), 4'd0, 16'hFFFF);
      5: send_instr(OP_STO, $urandom(), 4'd0, 16'hFFFF);
      default: begin
        send_instr(OP_INC, 4'd0, 4'd0, 60 - sp);
        send_instr(OP_CAL, 4'd0, 4'd0, 16'd7);
      end
    endcase
    repeat (6) send_instr($urandom(), $urandom(), $urandom(), $urandom());
    item_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    done = 1;
    if (fail_count == 0) begin
      $display("stack_frame_register_vm_core_unit: match");
    end else begin
      $display("stack_frame_register_vm_core_unit: mismatch");
    end
    $finish;
  end
endmodule
